>>> hdl/pftq_pkg.sv
// Shared types and constants for the projected FSQ token quantizer.
// Used by every module of the block except pftq_ram; depends on nothing else.
package pftq_pkg;

  localparam int unsigned FSQ_DIM   = 8;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned POS_W     = 11;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned TOKEN_W   = 13;
  localparam int unsigned THR_W     = 15;
  localparam int unsigned FRAC_W    = 12;
  localparam int unsigned PROD_W    = 2 * VALUE_W;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned BIASED_W  = SUM_W + 1;

  localparam int unsigned MAX_HIDDEN_DEFAULT = 2048;
  localparam int unsigned OUT_DEPTH          = 8;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 15'd2253;

  localparam logic [KIND_W-1:0] KIND_WEIGHT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BIAS   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HIDDEN = 2'd2;

  localparam logic [TOKEN_W-1:0] POW3 [FSQ_DIM] = '{
    13'd1, 13'd3, 13'd9, 13'd27, 13'd81, 13'd243, 13'd729, 13'd2187
  };

  typedef logic [FSQ_DIM-1:0][VALUE_W-1:0] lane_value_t;
  typedef logic [FSQ_DIM-1:0][SUM_W-1:0]   lane_sum_t;

  // Control that travels with an item through the accumulate pipeline.
  typedef struct packed {
    logic             valid;
    logic             hidden;
    logic             bias;
    logic             in_range;
    logic             last;
    logic [ROW_W-1:0] row;
  } acc_ctrl_t;

endpackage

>>> hdl/pftq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stand-alone; no package dependency.
module pftq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2048,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/pftq_accum.sv
// Eight multiply-accumulate lanes, the bias registers and the frame close.
// Depends on pftq_pkg; weights arrive from the row memories in the cycle after accept.
module pftq_accum (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  pftq_pkg::acc_ctrl_t     in_ctrl_i,
  input  logic [pftq_pkg::VALUE_W-1:0] in_value_i,
  input  pftq_pkg::lane_value_t   weights_i,
  output logic                    fin_valid_o,
  output pftq_pkg::lane_sum_t     fin_sum_o,
  output pftq_pkg::lane_value_t   fin_bias_o
);

  localparam int unsigned VW = pftq_pkg::VALUE_W;
  localparam int unsigned PW = pftq_pkg::PROD_W;
  localparam int unsigned SW = pftq_pkg::SUM_W;
  localparam int unsigned ND = pftq_pkg::FSQ_DIM;

  pftq_pkg::acc_ctrl_t s1_ctrl_q, s2_ctrl_q;
  logic [VW-1:0] s1_value_q, s2_value_q;
  logic signed [PW-1:0] prod_d [ND];
  logic signed [PW-1:0] prod_q [ND];

  pftq_pkg::lane_sum_t   acc_q, acc_d, fin_sum_q, fin_sum_d;
  pftq_pkg::lane_value_t bias_q, bias_d, fin_bias_q;
  logic                  fin_valid_q, fin_valid_d;

  // Stage 1 has the weights from memory; form the eight products.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      prod_d[j] = $signed(weights_i[j]) * $signed(s1_value_q);
    end
  end

  // Stage 2 applies bias loads and accumulates in item order.
  always_comb begin
    logic [SW-1:0] addend;
    logic [SW-1:0] total;
    acc_d       = acc_q;
    bias_d      = bias_q;
    fin_sum_d   = fin_sum_q;
    fin_valid_d = 1'b0;
    if (s2_ctrl_q.valid && s2_ctrl_q.bias) begin
      bias_d[s2_ctrl_q.row] = s2_value_q;
    end
    for (int j = 0; j < ND; j++) begin
      addend = s2_ctrl_q.in_range ? {{(SW-PW){prod_q[j][PW-1]}}, prod_q[j]} : '0;
      total  = acc_q[j] + addend;
      if (s2_ctrl_q.valid && s2_ctrl_q.hidden) begin
        if (s2_ctrl_q.last) begin
          fin_sum_d[j] = total;
          acc_d[j]     = '0;
        end else begin
          acc_d[j] = total;
        end
      end
    end
    fin_valid_d = s2_ctrl_q.valid && s2_ctrl_q.hidden && s2_ctrl_q.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctrl_q   <= '0;
      s2_ctrl_q   <= '0;
      acc_q       <= '0;
      bias_q      <= '0;
      fin_valid_q <= 1'b0;
    end else begin
      s1_ctrl_q   <= in_ctrl_i;
      s2_ctrl_q   <= s1_ctrl_q;
      acc_q       <= acc_d;
      bias_q      <= bias_d;
      fin_valid_q <= fin_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_value_q <= in_value_i;
    s2_value_q <= s1_value_q;
    for (int j = 0; j < ND; j++) begin
      prod_q[j] <= prod_d[j];
    end
    fin_sum_q <= fin_sum_d;
    if (fin_valid_d) begin
      fin_bias_q <= bias_q;
    end
  end

  assign fin_valid_o = fin_valid_q;
  assign fin_sum_o   = fin_sum_q;
  assign fin_bias_o  = fin_bias_q;

endmodule

>>> hdl/pftq_quant.sv
// Bias alignment, three-level decision per lane and base-3 token packing.
// Depends on pftq_pkg; fed by pftq_accum at the close of a frame.
module pftq_quant (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fin_valid_i,
  input  pftq_pkg::lane_sum_t         fin_sum_i,
  input  pftq_pkg::lane_value_t       fin_bias_i,
  input  logic [pftq_pkg::THR_W-1:0]  threshold_i,
  output logic                        tok_valid_o,
  output logic [pftq_pkg::TOKEN_W-1:0] tok_o
);

  localparam int unsigned ND = pftq_pkg::FSQ_DIM;
  localparam int unsigned BW = pftq_pkg::BIASED_W;
  localparam int unsigned SW = pftq_pkg::SUM_W;
  localparam int unsigned VW = pftq_pkg::VALUE_W;
  localparam int unsigned FW = pftq_pkg::FRAC_W;
  localparam int unsigned TW = pftq_pkg::THR_W;
  localparam int unsigned KW = pftq_pkg::TOKEN_W;

  localparam logic [1:0] DIGIT_LOW  = 2'd0;
  localparam logic [1:0] DIGIT_MID  = 2'd1;
  localparam logic [1:0] DIGIT_HIGH = 2'd2;

  logic [BW-1:0] biased_d [ND];
  logic [BW-1:0] biased_q [ND];
  logic [1:0]    digit_d  [ND];
  logic [1:0]    digit_q  [ND];
  logic          biased_valid_q, digit_valid_q;
  logic signed [BW-1:0] thr_pos, thr_neg;

  assign thr_pos = $signed({{(BW-TW-FW){1'b0}}, threshold_i, {FW{1'b0}}});
  assign thr_neg = -thr_pos;

  // The sum can exceed 48 bits once the bias is added, so one guard bit is kept.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      biased_d[j] = {fin_sum_i[j][SW-1], fin_sum_i[j]}
                  + {{(BW-VW-FW){fin_bias_i[j][VW-1]}}, fin_bias_i[j], {FW{1'b0}}};
    end
  end

  // The upper test wins, so a zero threshold sends a zero sum to the top level.
  always_comb begin
    for (int j = 0; j < ND; j++) begin
      if ($signed(biased_q[j]) >= thr_pos) begin
        digit_d[j] = DIGIT_HIGH;
      end else if ($signed(biased_q[j]) <= thr_neg) begin
        digit_d[j] = DIGIT_LOW;
      end else begin
        digit_d[j] = DIGIT_MID;
      end
    end
  end

  always_comb begin
    logic [KW-1:0] acc;
    acc = '0;
    for (int j = 0; j < ND; j++) begin
      case (digit_q[j])
        DIGIT_HIGH: acc = acc + (pftq_pkg::POW3[j] << 1);
        DIGIT_MID:  acc = acc + pftq_pkg::POW3[j];
        default:    acc = acc;
      endcase
    end
    tok_o = acc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biased_valid_q <= 1'b0;
      digit_valid_q  <= 1'b0;
    end else begin
      biased_valid_q <= fin_valid_i;
      digit_valid_q  <= biased_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < ND; j++) begin
      biased_q[j] <= biased_d[j];
      digit_q[j]  <= digit_d[j];
    end
  end

  assign tok_valid_o = digit_valid_q;

endmodule

>>> hdl/pftq_outq.sv
// Small result queue that decouples the pipeline from the output stream.
// Depends on pftq_pkg for its default depth and item width.
module pftq_outq #(
  parameter int unsigned DEPTH = pftq_pkg::OUT_DEPTH,
  parameter int unsigned WIDTH = pftq_pkg::TOKEN_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_pop;

  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

endmodule

>>> hdl/projected_fsq_token_quantizer_unit.sv
// Top level of the projected FSQ token quantizer.
// Depends on pftq_pkg, pftq_ram, pftq_accum, pftq_quant and pftq_outq.
//
// Usage: the slave stream carries three kinds of item, chosen by s_axis_tuser:
// weight loads and bias loads fill the projection, and hidden elements of a
// frame are multiplied against the eight weight rows and summed. A hidden
// element with s_axis_tlast high closes the frame: the biases are added, each
// sum becomes a base-3 digit against the threshold, and one token leaves on the
// master stream. The threshold is written through the cfg channel, which is
// always ready and must only be used while the block is idle.
// Throughput is one item per cycle while s_axis_tready is high: the eight weight row
// memories are read once per item and feed eight parallel multiply-accumulate lanes.
// A closing element passes the stage-1, stage-2 and frame-close registers of
// pftq_accum and the biased and digit registers of pftq_quant into the queue.
// Reset clears the accumulators, biases and queue and restores the threshold;
// the weight memories hold no reset value and must be loaded before use.
// When the receiver stalls, tokens wait in an eight-deep queue; s_axis_tready
// drops only once eight frame closes are pending, so nothing is ever lost.
module projected_fsq_token_quantizer_unit #(
  parameter int unsigned MAX_HIDDEN = pftq_pkg::MAX_HIDDEN_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Bits from the lowest: row [2:0], position [13:3], value [29:14], zero pad [31:30].
  input  logic [31:0] s_axis_tdata,
  // Bits from the lowest: kind [1:0].
  input  logic [1:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Bits from the lowest: token [12:0], zero pad [15:13].
  output logic [15:0] m_axis_tdata,
  // Threshold write channel.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [14:0] cfg_data_i
);

  localparam int unsigned ND   = pftq_pkg::FSQ_DIM;
  localparam int unsigned RW   = pftq_pkg::ROW_W;
  localparam int unsigned PSW  = pftq_pkg::POS_W;
  localparam int unsigned VW   = pftq_pkg::VALUE_W;
  localparam int unsigned KW   = pftq_pkg::TOKEN_W;
  localparam int unsigned AW   = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
  localparam int unsigned CW   = $clog2(pftq_pkg::OUT_DEPTH + 1);

  // Field unpacking of the input item.
  logic [RW-1:0]  in_row;
  logic [PSW-1:0] in_pos;
  logic [VW-1:0]  in_value;
  logic [1:0]     in_kind;
  logic           in_accept, in_range, close_accept;
  logic [AW-1:0]  in_addr;

  assign in_row   = s_axis_tdata[RW-1:0];
  assign in_pos   = s_axis_tdata[RW+PSW-1:RW];
  assign in_value = s_axis_tdata[RW+PSW+VW-1:RW+PSW];
  assign in_kind  = s_axis_tuser;
  assign in_range = (32'(in_pos) < MAX_HIDDEN);
  assign in_addr  = AW'(in_pos);

  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign close_accept = in_accept && (in_kind == pftq_pkg::KIND_HIDDEN) && s_axis_tlast;

  // Threshold register; the channel never stalls.
  logic [pftq_pkg::THR_W-1:0] threshold_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= pftq_pkg::THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  // One memory per projection row. Weight loads write at accept and hidden
  // elements read at accept, so the memory sees accesses in stream order and
  // a later element always observes an earlier load.
  pftq_pkg::lane_value_t weights;

  for (genvar j = 0; j < ND; j++) begin : g_row
    logic row_we;
    assign row_we = in_accept && (in_kind == pftq_pkg::KIND_WEIGHT) && in_range
                 && (in_row == RW'(j));
    pftq_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_HIDDEN)
    ) u_weight_row (
      .clk_i   (clk_i),
      .we_i    (row_we),
      .waddr_i (in_addr),
      .wdata_i (in_value),
      .raddr_i (in_addr),
      .rdata_o (weights[j])
    );
  end

  // Control that follows each accepted item into the accumulate lanes.
  pftq_pkg::acc_ctrl_t in_ctrl;

  always_comb begin
    in_ctrl          = '0;
    in_ctrl.valid    = in_accept;
    in_ctrl.hidden   = (in_kind == pftq_pkg::KIND_HIDDEN);
    in_ctrl.bias     = (in_kind == pftq_pkg::KIND_BIAS);
    in_ctrl.in_range = in_range;
    in_ctrl.last     = s_axis_tlast;
    in_ctrl.row      = in_row;
  end

  logic                  fin_valid;
  pftq_pkg::lane_sum_t   fin_sum;
  pftq_pkg::lane_value_t fin_bias;

  pftq_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctrl_i   (in_ctrl),
    .in_value_i  (in_value),
    .weights_i   (weights),
    .fin_valid_o (fin_valid),
    .fin_sum_o   (fin_sum),
    .fin_bias_o  (fin_bias)
  );

  logic          tok_valid;
  logic [KW-1:0] tok;

  pftq_quant u_quant (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_valid_i (fin_valid),
    .fin_sum_i   (fin_sum),
    .fin_bias_i  (fin_bias),
    .threshold_i (threshold_q),
    .tok_valid_o (tok_valid),
    .tok_o       (tok)
  );

  logic [KW-1:0] out_token;

  pftq_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (tok_valid),
    .data_i  (tok),
    .pop_i   (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_token)
  );

  assign m_axis_tdata = {{(16-KW){1'b0}}, out_token};

  // Count of frame closes accepted whose tokens have not yet left. Input is taken
  // only while it is below the queue depth, so every token in flight has a slot.
  logic [CW-1:0] pending_q, pending_d;
  logic          out_accept;

  assign out_accept    = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (pending_q < CW'(pftq_pkg::OUT_DEPTH));

  always_comb begin
    pending_d = pending_q;
    if (close_accept && !out_accept) begin
      pending_d = pending_q + 1'b1;
    end else if (!close_accept && out_accept) begin
      pending_d = pending_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for projected_fsq_token_quantizer_unit.
// Needs only pftq_pkg and the block's RTL; a built-in projection predictor
// computes every token and the monitor compares each one as it leaves.
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned KIND_W             = pftq_pkg::KIND_W;
  localparam int unsigned ROW_W              = pftq_pkg::ROW_W;
  localparam int unsigned POS_W              = pftq_pkg::POS_W;
  localparam int unsigned VALUE_W            = pftq_pkg::VALUE_W;
  localparam int unsigned TOKEN_W            = pftq_pkg::TOKEN_W;
  localparam int unsigned THR_W              = pftq_pkg::THR_W;
  localparam int unsigned PROD_W             = pftq_pkg::PROD_W;
  localparam int unsigned SUM_W              = pftq_pkg::SUM_W;
  localparam int unsigned FSQ_DIM            = pftq_pkg::FSQ_DIM;
  localparam int unsigned MAX_HIDDEN_DEFAULT = pftq_pkg::MAX_HIDDEN_DEFAULT;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = pftq_pkg::THRESHOLD_RESET;
  localparam logic [KIND_W-1:0] KIND_WEIGHT     = pftq_pkg::KIND_WEIGHT;
  localparam logic [KIND_W-1:0] KIND_BIAS       = pftq_pkg::KIND_BIAS;
  localparam logic [KIND_W-1:0] KIND_HIDDEN     = pftq_pkg::KIND_HIDDEN;

  localparam int unsigned HIDDEN_LIMIT   = MAX_HIDDEN_DEFAULT;
  localparam int unsigned ROWS           = FSQ_DIM;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  // Settling wait after draining, well beyond the path from close to token.
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  // The longest correct quiet stretch is the receiver hold plus the pipeline,
  // so a far longer stretch with no transfer anywhere means a hang.
  localparam int unsigned STALL_LIMIT    = 5000;
  localparam int unsigned MAX_REPORTS    = 10;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [ROW_W-1:0]   row;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    logic               last;
  } stream_item_t;

  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata  = '0;
  logic [1:0]         s_axis_tuser  = '0;
  logic               s_axis_tlast  = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [15:0]        m_axis_tdata;
  logic               cfg_valid_i   = 1'b0;
  logic               cfg_ready_o;
  logic [THR_W-1:0]   cfg_data_i    = '0;

  always #5 clk = ~clk;

  projected_fsq_token_quantizer_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Items waiting to be offered, and the tokens the predictor expects.
  stream_item_t       pending_items[$];
  logic [TOKEN_W-1:0] token_expect_q[$];

  // Mirror of the block's state, updated at every accepted item.
  logic signed [VALUE_W-1:0] weight_mirror [ROWS*HIDDEN_LIMIT];
  logic signed [VALUE_W-1:0] bias_mirror   [ROWS];
  logic signed [SUM_W-1:0]   row_acc       [ROWS];
  logic [THR_W-1:0]          thr_mirror;

  // Generation-side bookkeeping: which positions have all eight rows loaded.
  // Hidden elements are only ever sent to such positions, so no weight entry
  // is read before it has been written.
  logic [ROWS-1:0] rows_loaded [HIDDEN_LIMIT] = '{default: '0};
  int unsigned     loaded_pos[$];

  int unsigned idle_pct = 28;
  int unsigned rx_hold_req = 0;
  int unsigned rx_hold_seen = 0;
  int unsigned rx_hold_left = 0;
  logic        in_taken = 1'b0;
  int unsigned thr_writes = 0;
  int unsigned stall_cycles = 0;

  int unsigned items_taken = 0;
  int unsigned weight_loads = 0;
  int unsigned bias_loads = 0;
  int unsigned tokens_checked = 0;
  int unsigned thr_settings = 1;
  int unsigned fail_count = 0;

  // Applies one accepted item to the mirror and queues the token it closes.
  function automatic void predict_fsq_item(stream_item_t it);
    logic signed [PROD_W-1:0] prod;
    longint                   sum_q24;
    longint                   thr_q24;
    int unsigned              place;
    int unsigned              digit;
    int unsigned              token;
    case (it.kind)
      KIND_WEIGHT: begin
        if (it.pos < HIDDEN_LIMIT) weight_mirror[it.row*HIDDEN_LIMIT + it.pos] = it.value;
      end
      KIND_BIAS: bias_mirror[it.row] = it.value;
      KIND_HIDDEN: begin
        if (it.pos < HIDDEN_LIMIT) begin
          for (int j = 0; j < ROWS; j++) begin
            prod = weight_mirror[j*HIDDEN_LIMIT + it.pos] * $signed(it.value);
            row_acc[j] = row_acc[j] + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
          end
        end
        if (it.last) begin
          // Bias Q4.12 and threshold UQ3.12 are lifted to the Q24.24 sums.
          thr_q24 = longint'(thr_mirror) * 64'sd4096;
          token = 0;
          place = 1;
          for (int j = 0; j < ROWS; j++) begin
            sum_q24 = longint'(row_acc[j]) + longint'(bias_mirror[j]) * 64'sd4096;
            // The upper test comes first, so a zero threshold sends zero to 2.
            if (sum_q24 >= thr_q24) digit = 2;
            else if (sum_q24 <= -thr_q24) digit = 0;
            else digit = 1;
            token += digit * place;
            place *= 3;
            row_acc[j] = '0;
          end
          token_expect_q.push_back(token[TOKEN_W-1:0]);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void queue_item(logic [KIND_W-1:0] kind, int unsigned row,
                                     int unsigned pos, logic [VALUE_W-1:0] value,
                                     logic last);
    stream_item_t it;
    it.kind  = kind;
    it.row   = row[ROW_W-1:0];
    it.pos   = pos[POS_W-1:0];
    it.value = value;
    it.last  = last;
    pending_items.push_back(it);
    if (kind == KIND_WEIGHT) begin
      if (rows_loaded[it.pos] != '1) begin
        rows_loaded[it.pos][it.row] = 1'b1;
        if (rows_loaded[it.pos] == '1) loaded_pos.push_back(it.pos);
      end
    end
  endfunction

  // Mostly values near one in Q4.12 so digits land on all three levels.
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned r;
    int          v;
    r = $urandom_range(0, 9);
    if (r < 4) return VALUE_W'($urandom);
    if (r < 7) v = int'($urandom_range(0, 8192)) - 4096;
    else if (r < 9) v = int'($urandom_range(0, 512)) - 256;
    else begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end
    return v[VALUE_W-1:0];
  endfunction

  // Well-formed traffic dominates: full weight columns, bias updates and
  // frames of one to six elements over loaded positions, with a little noise.
  function automatic void queue_random_items(int unsigned n);
    int unsigned made;
    int unsigned r;
    int unsigned p;
    int unsigned len;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (loaded_pos.size() < 4 || r < 12) begin
        p = $urandom_range(0, HIDDEN_LIMIT-1);
        for (int unsigned j = 0; j < ROWS; j++)
          queue_item(KIND_WEIGHT, j, p, pick_value(), 1'($urandom_range(0, 1)));
        made += ROWS;
      end else if (r < 18) begin
        queue_item(KIND_BIAS, $urandom_range(0, ROWS-1), $urandom_range(0, HIDDEN_LIMIT-1),
                   pick_value(), 1'($urandom_range(0, 1)));
        made++;
      end else if (r < 20) begin
        queue_item(KIND_UNUSED, $urandom_range(0, ROWS-1), $urandom_range(0, HIDDEN_LIMIT-1),
                   VALUE_W'($urandom), 1'($urandom_range(0, 1)));
      end else if (r < 23) begin
        queue_item(KIND_WEIGHT, $urandom_range(0, ROWS-1), $urandom_range(0, HIDDEN_LIMIT-1),
                   pick_value(), 1'($urandom_range(0, 1)));
        made++;
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          queue_item(KIND_HIDDEN, $urandom_range(0, ROWS-1),
                     loaded_pos[$urandom_range(0, loaded_pos.size()-1)],
                     pick_value(), k == len-1);
        made += len;
      end
    end
  endfunction

  // Source side: present the next item once the current one is gone.
  always @(negedge clk) begin
    stream_item_t it;
    if (!s_axis_tvalid || in_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        it = pending_items.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, it.value, it.pos, it.row};
        s_axis_tuser  <= it.kind;
        s_axis_tlast  <= it.last;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Sink side: random backpressure, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (rx_hold_req != rx_hold_seen) begin
      rx_hold_seen = rx_hold_req;
      rx_hold_left = RX_HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  task automatic note_mismatch(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: MISMATCH %s", $realtime, msg);
  endtask

  // Monitor: checks leaving tokens, feeds accepted items and threshold
  // writes to the predictor, and watches for a stuck block.
  always @(posedge clk) begin
    stream_item_t       it;
    logic [TOKEN_W-1:0] want;
    logic               moved;
    moved = 1'b0;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      moved = 1'b1;
      if (token_expect_q.size() == 0) begin
        note_mismatch($sformatf("token %0d with none expected", m_axis_tdata[TOKEN_W-1:0]));
      end else begin
        want = token_expect_q.pop_front();
        tokens_checked++;
        if (m_axis_tdata[TOKEN_W-1:0] !== want)
          note_mismatch($sformatf("token expected %0d got %0d", want,
                                  m_axis_tdata[TOKEN_W-1:0]));
      end
    end
    in_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni && in_taken) begin
      moved = 1'b1;
      it.row   = s_axis_tdata[ROW_W-1:0];
      it.pos   = s_axis_tdata[ROW_W +: POS_W];
      it.value = s_axis_tdata[ROW_W+POS_W +: VALUE_W];
      it.kind  = s_axis_tuser;
      it.last  = s_axis_tlast;
      items_taken++;
      if (it.kind == KIND_WEIGHT) weight_loads++;
      if (it.kind == KIND_BIAS) bias_loads++;
      predict_fsq_item(it);
    end
    if (rst_ni && cfg_valid_i && cfg_ready_o) begin
      moved = 1'b1;
      thr_mirror = cfg_data_i;
      thr_writes++;
    end
    if (moved || !rst_ni) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Returns once every item went in, every token came out and the
  // pipeline has had time to settle.
  task automatic wait_drained();
    while (pending_items.size() != 0 || s_axis_tvalid || token_expect_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    int unsigned seen;
    seen = thr_writes;
    cfg_data_i  <= thr;
    cfg_valid_i <= 1'b1;
    do @(negedge clk); while (thr_writes == seen);
    cfg_valid_i <= 1'b0;
    thr_settings++;
  endtask

  task automatic run_phase(logic [THR_W-1:0] thr, int unsigned n);
    write_threshold(thr);
    queue_random_items(n);
    wait_drained();
  endtask

  initial begin
    for (int j = 0; j < ROWS; j++) begin
      bias_mirror[j] = '0;
      row_acc[j]     = '0;
    end
    thr_mirror = THRESHOLD_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);

    // Directed part at the reset threshold: extreme weights in column zero,
    // a last mark on a load, extreme biases, an unused kind and short frames.
    queue_item(KIND_WEIGHT, 0, 0, 16'h8000, 1'b0);
    queue_item(KIND_WEIGHT, 1, 0, 16'h7fff, 1'b0);
    queue_item(KIND_WEIGHT, 2, 0, 16'h0000, 1'b0);
    queue_item(KIND_WEIGHT, 3, 0, 16'h0001, 1'b1);
    queue_item(KIND_WEIGHT, 4, 0, 16'hffff, 1'b0);
    queue_item(KIND_WEIGHT, 5, 0, 16'h1000, 1'b0);
    queue_item(KIND_WEIGHT, 6, 0, 16'hf000, 1'b0);
    queue_item(KIND_WEIGHT, 7, 0, 16'h0800, 1'b0);
    queue_item(KIND_BIAS,   0, 0, 16'h7fff, 1'b1);
    queue_item(KIND_BIAS,   7, 0, 16'h8000, 1'b0);
    queue_item(KIND_UNUSED, 7, HIDDEN_LIMIT-1, 16'hffff, 1'b1);
    queue_item(KIND_HIDDEN, 0, 0, 16'h7fff, 1'b0);
    queue_item(KIND_HIDDEN, 0, 0, 16'h8000, 1'b1);
    queue_item(KIND_HIDDEN, 0, 0, 16'h0000, 1'b1);
    queue_item(KIND_HIDDEN, 0, 0, 16'h0001, 1'b1);
    wait_drained();

    // With a zero threshold an exact zero sum must give the top digit.
    write_threshold('0);
    queue_item(KIND_BIAS,   0, 0, 16'h0000, 1'b0);
    queue_item(KIND_BIAS,   7, 0, 16'h0000, 1'b0);
    queue_item(KIND_HIDDEN, 0, 0, 16'h0000, 1'b1);
    queue_item(KIND_HIDDEN, 0, 0, 16'hffff, 1'b1);
    wait_drained();

    write_threshold('1);
    queue_item(KIND_HIDDEN, 0, 0, 16'h8000, 1'b0);
    queue_item(KIND_HIDDEN, 0, 0, 16'h8000, 1'b1);
    wait_drained();

    // Random phases, each under its own threshold.
    run_phase('1, 190);
    run_phase('0, 190);

    // No idling on either side for this whole phase.
    idle_pct = 0;
    run_phase(15'($urandom_range(0, 32767)), 190);
    idle_pct = 28;

    // The sink holds off while a burst of one-element frames arrives, so the
    // token queue fills and the input must stall.
    write_threshold(15'd1);
    rx_hold_req++;
    for (int k = 0; k < 40; k++)
      queue_item(KIND_HIDDEN, $urandom_range(0, ROWS-1),
                 loaded_pos[$urandom_range(0, loaded_pos.size()-1)], pick_value(), 1'b1);
    queue_random_items(150);
    wait_drained();

    run_phase(THRESHOLD_RESET, 190);
    run_phase(15'($urandom_range(512, 8192)), 190);

    $display("Run covered %0d items (%0d weight loads, %0d bias loads) under %0d thresholds.",
             items_taken, weight_loads, bias_loads, thr_settings);
    $display("Checked %0d tokens, %0d mismatches.", tokens_checked, fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
